/* design/mpd_pkg.sv */
package mpd_pkg;

	localparam int MAX_PINS = 16;
	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 16;
	localparam int PCNT_W   = 5;
	localparam int MODE_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef logic [MAX_PINS-1:0] pin_vec_t;
	typedef logic [TIME_W-1:0]   time_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [MODE_W-1:0]   mode_t;

	// debounce modes; the unused code behaves as MODE_NONE
	localparam mode_t MODE_NONE  = 2'd0;
	localparam mode_t MODE_DELAY = 2'd1;
	localparam mode_t MODE_INTEG = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIN_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 2'd3;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_FETCH  = 1'b1;

	localparam count_t COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic   sample_en;
		logic   fetch_en;
		mode_t  mode;
		time_t  now;
		time_t  delay;
		count_t threshold;
	} lane_ctrl_t;

endpackage

/* design/mpd_req_if.sv */
interface mpd_req_if;
	logic              valid;
	logic              ready;
	logic              req_type;
	mpd_pkg::pin_vec_t pin_levels;
	mpd_pkg::time_t    now_us;

	modport source (output valid, output req_type, output pin_levels, output now_us,
		input ready);
	modport sink (input valid, input req_type, input pin_levels, input now_us,
		output ready);
endinterface

/* design/mpd_rsp_if.sv */
interface mpd_rsp_if;
	logic              valid;
	logic              ready;
	mpd_pkg::pin_vec_t debounced_values;
	mpd_pkg::pin_vec_t invalid_mask;

	modport source (output valid, output debounced_values, output invalid_mask,
		input ready);
	modport sink (input valid, input debounced_values, input invalid_mask,
		output ready);
endinterface

/* design/mpd_pin_lane.sv */
module mpd_pin_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  mpd_pkg::lane_ctrl_t ctrl,
	input  logic                in_use,
	input  logic                cur,
	output logic                res_level,
	output logic                res_invalid
);
	import mpd_pkg::*;

	logic   acc_q, prev_q, run_q, inv_q;
	time_t  ct_q;
	count_t cnt_q;

	logic   acc_d, prev_d, run_d, inv_d;
	time_t  ct_d;
	count_t cnt_d;

	logic   changed, run_mid, pass;
	time_t  ct_mid, elapsed;
	count_t cnt_mid;
	logic   reached;

	always_comb begin
		changed = cur ^ prev_q;
		ct_mid  = changed ? ctrl.now : ct_q;
		run_mid = run_q | changed;
		elapsed = ctrl.now - ct_mid;
		pass    = run_mid && (elapsed >= ctrl.delay);

		if (changed) begin
			cnt_mid = (cnt_q != '0) ? cnt_q - count_t'(1) : cnt_q;
		end else begin
			cnt_mid = (cnt_q != COUNT_MAX) ? cnt_q + count_t'(1) : cnt_q;
		end
		reached = (cnt_mid >= ctrl.threshold);

		acc_d  = acc_q;
		prev_d = prev_q;
		run_d  = run_q;
		inv_d  = inv_q;
		ct_d   = ct_q;
		cnt_d  = cnt_q;

		case (ctrl.mode)
			MODE_DELAY: begin
				prev_d = cur;
				if (in_use) begin
					ct_d  = ct_mid;
					run_d = pass ? 1'b0 : run_mid;
					inv_d = pass ? changed : (inv_q | changed);
					if (pass && !changed) begin
						acc_d = cur;
					end
				end
			end
			MODE_INTEG: begin
				prev_d = cur;
				if (in_use) begin
					cnt_d = cnt_mid;
					if (reached) begin
						acc_d = cur;
						inv_d = 1'b0;
					end else if (cnt_mid == '0) begin
						inv_d = 1'b1;
					end
				end
			end
			default: begin
				acc_d = cur;
			end
		endcase

		// a fetch reports the state as it stands, then clears it
		if (ctrl.fetch_en) begin
			res_level   = acc_q;
			res_invalid = inv_q;
		end else begin
			res_level   = acc_d;
			res_invalid = inv_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= 1'b1;
			prev_q <= 1'b1;
			run_q  <= 1'b0;
			inv_q  <= 1'b1;
			ct_q   <= '0;
			cnt_q  <= '0;
		end else if (ctrl.fetch_en) begin
			acc_q  <= 1'b1;
			prev_q <= 1'b1;
			run_q  <= 1'b0;
			inv_q  <= 1'b1;
			ct_q   <= '0;
			cnt_q  <= '0;
		end else if (ctrl.sample_en) begin
			acc_q  <= acc_d;
			prev_q <= prev_d;
			run_q  <= run_d;
			inv_q  <= inv_d;
			ct_q   <= ct_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

/* design/multi_pin_debouncer_unit.sv */
// Pipeline: an item is captured in the input register when accepted; its result
// goes to the result register, and pin state is updated, as the item leaves the
// input register, which waits while an unaccepted result is held.
// Throughput: one item per cycle unless stalled; one lane per pin, all in parallel.
// Reset: asynchronous, active low; empties both stages, sets the registers to mode
// none, 16 pins, threshold 0, delay 0, and puts every pin in its power-up state.
module multi_pin_debouncer_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	mpd_req_if.sink                             req,
	mpd_rsp_if.source                           rsp,
	input  logic                                cfg_we,
	input  logic [mpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mpd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import mpd_pkg::*;

	mode_t              mode_q;
	logic [PCNT_W-1:0]  pin_count_q;
	count_t             threshold_q;
	time_t              delay_q;

	logic               valid_s1;
	logic               req_type_s1;
	pin_vec_t           pins_s1;
	time_t              now_s1;

	logic               valid_s2;
	pin_vec_t           values_s2;
	pin_vec_t           mask_s2;

	logic               adv_s1;
	logic [PCNT_W-1:0]  pins_used;
	pin_vec_t           in_use;
	pin_vec_t           reading;
	pin_vec_t           res_values;
	pin_vec_t           res_mask;
	lane_ctrl_t         ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NONE;
			pin_count_q <= PCNT_W'(MAX_PINS);
			threshold_q <= '0;
			delay_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:      mode_q      <= cfg_wdata[MODE_W-1:0];
				CFG_PIN_COUNT: pin_count_q <= cfg_wdata[PCNT_W-1:0];
				CFG_THRESHOLD: threshold_q <= cfg_wdata[COUNT_W-1:0];
				CFG_DELAY:     delay_q     <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;

	assign pins_used = (pin_count_q > PCNT_W'(MAX_PINS)) ? PCNT_W'(MAX_PINS) : pin_count_q;

	genvar i;
	generate
		for (i = 0; i < MAX_PINS; i++) begin : g_use
			assign in_use[i] = (PCNT_W'(i) < pins_used);
		end
	endgenerate

	// unused pins read as low
	assign reading = pins_s1 & in_use;

	always_comb begin
		ctrl.sample_en = adv_s1 && (req_type_s1 == REQ_SAMPLE);
		ctrl.fetch_en  = adv_s1 && (req_type_s1 == REQ_FETCH);
		ctrl.mode      = mode_q;
		ctrl.now       = now_s1;
		ctrl.delay     = delay_q;
		ctrl.threshold = threshold_q;
	end

	generate
		for (i = 0; i < MAX_PINS; i++) begin : g_lane
			mpd_pin_lane u_lane (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.in_use      (in_use[i]),
				.cur         (reading[i]),
				.res_level   (res_values[i]),
				.res_invalid (res_mask[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			pins_s1     <= req.pin_levels;
			now_s1      <= req.now_us;
		end
		if (adv_s1) begin
			values_s2 <= res_values;
			mask_s2   <= res_mask;
		end
	end

	assign rsp.valid            = valid_s2;
	assign rsp.debounced_values = values_s2;
	assign rsp.invalid_mask     = mask_s2;

endmodule

/* design/mpd_checker.sv */
module mpd_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  mpd_pkg::pin_vec_t debounced_values,
	input  mpd_pkg::pin_vec_t invalid_mask
);
	import mpd_pkg::*;

	logic [1:0] inflight_q;
	logic       req_acc, rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(req_acc) - 2'(rsp_acc);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(debounced_values)
			&& $stable(invalid_mask))
		else $error("result item changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> inflight_q != 2'd0)
		else $error("result item without an accepted item");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 2'd2)
		else $error("more items in flight than stages");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 2'd2 && rsp_valid && !rsp_ready |-> !req_ready)
		else $error("item accepted while both stages are full");

endmodule

bind multi_pin_debouncer_unit mpd_checker u_mpd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.debounced_values (rsp.debounced_values),
	.invalid_mask     (rsp.invalid_mask)
);

/* tb/tb_top.sv */
module tb_top;
	import mpd_pkg::*;

	localparam int    HALF_PERIOD = 5;
	localparam mode_t MODE_UNUSED = 2'd3;

	typedef struct packed {
		pin_vec_t values;
		pin_vec_t mask;
	} pin_report_t;

	// Tracks the debounced pin state and queues the report each item should produce
	class debounce_tracker;
		mode_t                  mode;
		logic [PCNT_W-1:0]      pin_count;
		count_t                 threshold;
		time_t                  delay_us;
		pin_vec_t               accepted;
		pin_vec_t               last_sample;
		pin_vec_t               timing;
		pin_vec_t               invalid;
		time_t                  changed_at [MAX_PINS];
		count_t                 agree [MAX_PINS];
		pin_report_t            pending_reports [$];
		int                     errors;

		function new();
			mode = MODE_NONE;
			pin_count = PCNT_W'(MAX_PINS);
			threshold = '0;
			delay_us = '0;
			errors = 0;
			clear_pins();
		endfunction

		function void clear_pins();
			accepted = '1;
			last_sample = '1;
			timing = '0;
			invalid = '1;
			foreach (changed_at[i]) begin
				changed_at[i] = '0;
				agree[i] = '0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_MODE: mode = data[MODE_W-1:0];
				CFG_PIN_COUNT: pin_count = data[PCNT_W-1:0];
				CFG_THRESHOLD: threshold = data[COUNT_W-1:0];
				CFG_DELAY: delay_us = data;
				default: ;
			endcase
		endfunction

		function void note_item(logic kind, pin_vec_t levels, time_t now);
			int       n;
			pin_vec_t reading;
			time_t    elapsed;
			logic     cur;
			logic     prev;
			n = (pin_count > MAX_PINS) ? MAX_PINS : int'(pin_count);
			reading = levels & pin_vec_t'((32'd1 << n) - 32'd1);
			if (kind == REQ_FETCH) begin
				pending_reports.push_back({accepted, invalid});
				clear_pins();
				return;
			end
			if (mode == MODE_DELAY) begin
				for (int i = 0; i < n; i++) begin
					cur = reading[i];
					prev = last_sample[i];
					if (cur != prev) begin
						changed_at[i] = now;
						timing[i] = 1'b1;
						invalid[i] = 1'b1;
					end
					elapsed = now - changed_at[i];
					if (timing[i] && elapsed >= delay_us) begin
						if (cur == prev) begin
							invalid[i] = 1'b0;
							accepted[i] = cur;
						end else begin
							invalid[i] = 1'b1;
						end
						timing[i] = 1'b0;
					end
				end
				last_sample = reading;
			end else if (mode == MODE_INTEG) begin
				for (int i = 0; i < n; i++) begin
					cur = reading[i];
					prev = last_sample[i];
					if (cur == prev) begin
						if (agree[i] != COUNT_MAX)
							agree[i] = agree[i] + 1'b1;
					end else if (agree[i] != '0) begin
						agree[i] = agree[i] - 1'b1;
					end
					if (agree[i] >= threshold) begin
						accepted[i] = cur;
						invalid[i] = 1'b0;
					end else if (agree[i] == '0) begin
						invalid[i] = 1'b1;
					end
				end
				last_sample = reading;
			end else begin
				accepted = reading;
			end
			pending_reports.push_back({accepted, invalid});
		endfunction

		task report(string what, pin_vec_t got, pin_vec_t want);
			errors++;
			$display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
		endtask

		task check_result(pin_vec_t values, pin_vec_t mask);
			pin_report_t want;
			if (pending_reports.size() == 0) begin
				report("result with no item waiting, debounced_values", values, '0);
				return;
			end
			want = pending_reports.pop_front();
			if (values !== want.values)
				report("debounced_values", values, want.values);
			if (mask !== want.mask)
				report("invalid_mask", mask, want.mask);
		endtask

		function int pending();
			return pending_reports.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mpd_req_if req_if();
	mpd_rsp_if rsp_if();

	multi_pin_debouncer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	debounce_tracker tracker = new();

	bit       send_quiet;
	bit       recv_quiet;
	bit       hold_rsp;
	pin_vec_t pin_state;
	time_t    clock_us;

	always #HALF_PERIOD clk = ~clk;

	task automatic send_item(logic kind, pin_vec_t levels, time_t now);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.req_type <= kind;
		req_if.pin_levels <= levels;
		req_if.now_us <= now;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		tracker.note_item(kind, levels, now);
	endtask

	// hold the sender until every queued report has come back
	task automatic drain();
		req_if.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		tracker.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic configure(mode_t mode, int pins, count_t thr, time_t delay);
		drain();
		write_reg(CFG_MODE, CFG_DATA_W'(mode));
		write_reg(CFG_PIN_COUNT, CFG_DATA_W'(pins));
		write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
		write_reg(CFG_DELAY, delay);
		cfg_we <= 1'b0;
	endtask

	// mostly short steps so that delays run out; now and then a jump that wraps
	function automatic time_t time_step();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return time_t'($urandom_range(0, 8));
		else if (roll < 9)
			return time_t'($urandom_range(0, 64));
		return time_t'($urandom);
	endfunction

	task automatic random_run(int count);
		int roll;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 4) begin
				send_item(REQ_FETCH, pin_vec_t'($urandom), time_t'($urandom));
			end else begin
				roll = $urandom_range(0, 99);
				if (roll >= 95)
					pin_state = pin_vec_t'($urandom);
				else if (roll >= 60)
					pin_state = pin_state ^ (pin_vec_t'(1) << $urandom_range(0, MAX_PINS - 1));
				clock_us = clock_us + time_step();
				send_item(REQ_SAMPLE, pin_state, clock_us);
			end
			if ($urandom_range(0, 99) == 0)
				drain();
		end
	endtask

	task automatic run_phase(mode_t mode, int pins, count_t thr, time_t delay, int count,
		bit sq, bit rq);
		configure(mode, pins, thr, delay);
		send_quiet = sq;
		recv_quiet = rq;
		random_run(count);
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				stall = 300;
			end else begin
				stall = recv_quiet ? 0 : $urandom_range(0, 19);
			end
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid) @(posedge clk);
			tracker.check_result(rsp_if.debounced_values, rsp_if.invalid_mask);
		end
	end

	initial begin
		#(2_000_000 * 2 * HALF_PERIOD);
		$display("multi_pin_debouncer_unit regression: fail");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MODE;
		cfg_wdata <= '0;
		req_if.valid <= 1'b0;
		req_if.req_type <= REQ_SAMPLE;
		req_if.pin_levels <= '0;
		req_if.now_us <= '0;
		rsp_if.ready <= 1'b0;
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
		hold_rsp = 1'b0;
		pin_state = '1;
		clock_us = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// power-up settings: levels follow the pins, fetch clears
		send_item(REQ_SAMPLE, 16'hFFFF, 32'h0000_0000);
		send_item(REQ_SAMPLE, 16'h0000, 32'hFFFF_FFFF);
		send_item(REQ_SAMPLE, 16'hA5C3, 32'h8000_0000);
		send_item(REQ_FETCH, 16'h1234, 32'h0000_0005);
		send_item(REQ_FETCH, 16'hFFFF, 32'hFFFF_FFFF);
		configure(MODE_NONE, 0, '0, '0);
		send_item(REQ_SAMPLE, 16'hFFFF, 32'h0000_0001);
		// longest delay: only an elapsed time of all ones passes, across the wrap
		configure(MODE_DELAY, 16, '0, 32'hFFFF_FFFF);
		send_item(REQ_SAMPLE, 16'hFFFE, 32'h0000_0001);
		send_item(REQ_SAMPLE, 16'hFFFE, 32'h0000_0000);
		send_item(REQ_SAMPLE, 16'h7FFE, 32'h0000_0005);
		// pin count above the maximum, zero delay
		configure(MODE_DELAY, 20, '0, '0);
		send_item(REQ_SAMPLE, 16'h0F0F, 32'h0000_0006);
		send_item(REQ_SAMPLE, 16'h0F0F, 32'h0000_0007);
		send_item(REQ_FETCH, 16'h0000, 32'h0000_0000);
		configure(MODE_INTEG, 16, 16'd2, '0);
		send_item(REQ_SAMPLE, 16'hFFFF, 32'h0000_0000);
		send_item(REQ_SAMPLE, 16'hFFFF, 32'h0000_0000);
		send_item(REQ_SAMPLE, 16'hFF00, 32'h0000_0000);
		send_item(REQ_SAMPLE, 16'h00FF, 32'h0000_0000);
		send_item(REQ_SAMPLE, 16'hFFFF, 32'h0000_0000);
		configure(MODE_UNUSED, 16, '0, '0);
		send_item(REQ_SAMPLE, 16'h3C3C, 32'h0000_0000);

		run_phase(MODE_NONE, 16, '0, '0, 70, 1'b0, 1'b0);
		hold_rsp = 1'b1;
		run_phase(MODE_DELAY, 16, '0, 32'd12, 90, 1'b1, 1'b0);
		run_phase(MODE_DELAY, 5, '0, '0, 70, 1'b0, 1'b0);
		run_phase(MODE_INTEG, 16, 16'd3, '0, 90, 1'b1, 1'b1);
		run_phase(MODE_INTEG, 1, '0, '0, 60, 1'b0, 1'b0);
		run_phase(MODE_UNUSED, 17, 16'd1, 32'd7, 60, 1'b0, 1'b1);

		// highest threshold: counters climb without reaching it, then most pins count down
		configure(MODE_INTEG, 16, COUNT_MAX, '0);
		send_quiet = 1'b1;
		recv_quiet = 1'b1;
		send_item(REQ_FETCH, '0, '0);
		repeat (40) send_item(REQ_SAMPLE, 16'hFFFF, clock_us);
		send_item(REQ_SAMPLE, 16'h0001, clock_us);
		send_item(REQ_SAMPLE, 16'h0001, clock_us);

		run_phase(MODE_DELAY, 31, COUNT_MAX, 32'hFFFF_FFFF, 60, 1'b0, 1'b0);
		run_phase(MODE_INTEG, 0, COUNT_MAX, 32'd30, 50, 1'b0, 1'b0);
		run_phase(MODE_INTEG, 9, 16'd1, 32'd3, 90, 1'b0, 1'b0);
		run_phase(MODE_DELAY, 16, 16'd2, 32'd40, 120, 1'b1, 1'b0);
		run_phase(MODE_NONE, 0, 16'd5, '0, 50, 1'b0, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0)
			$display("multi_pin_debouncer_unit regression: pass");
		else
			$display("multi_pin_debouncer_unit regression: fail");
		$finish;
	end
endmodule
